// ===== hdl/mexp_pkg.sv =====
// ----------------------------------------------------------------------------
// mexp_pkg: shared types and constants for modular exponentiation
// Field widths of the stream payload and the sequencer state encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package mexp_pkg;

    localparam int BASE_W = 32;                     // base_value width
    localparam int EXP_W  = 63;                     // exponent width
    localparam int IN_W   = 96;                     // input tdata, byte padded
    localparam int OP_W   = 32;                     // scanned multiplier operand width

    typedef enum logic [2:0] {
        S_IDLE,
        S_BASE,     // base reduction: base * (1 mod m)
        S_MUL,      // acc * sq
        S_SQR,      // sq * sq
        S_DONE
    } state_t;

endpackage

`default_nettype wire

// ===== hdl/mexp_modmul.sv =====
// ----------------------------------------------------------------------------
// mexp_modmul: bit-serial modular multiplier
// Interleaved shift-add multiply, one bit of a per cycle, with the running
// remainder kept below m by up to two conditional subtractions.
// ----------------------------------------------------------------------------
`default_nettype none

module mexp_modmul #(
    parameter int MOD_BITS = 31
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [mexp_pkg::OP_W-1:0]     a,       // any value, scanned MSB first
    input  wire logic [MOD_BITS-1:0]           x,       // must be below m
    input  wire logic [MOD_BITS-1:0]           m,       // nonzero
    output logic                               done,
    output logic [MOD_BITS-1:0]                result
);
    import mexp_pkg::*;

    localparam int CNT_W = $clog2(OP_W + 1);
    localparam int T_W   = MOD_BITS + 2;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [OP_W-1:0]     a_reg, a_next;
    logic [MOD_BITS-1:0] x_reg, x_next;
    logic [MOD_BITS-1:0] m_reg, m_next;
    logic [MOD_BITS-1:0] r_reg, r_next;

    logic [T_W-1:0] sum;
    logic [T_W-1:0] sub1;
    logic [T_W-1:0] sub2;
    logic [T_W-1:0] m_ext;

    // r < m and x < m, so 2r + x < 3m: at most two subtractions
    always_comb
    begin
        m_ext = T_W'(m_reg);
        sum   = T_W'({r_reg, 1'b0}) + (a_reg[OP_W-1] ? T_W'(x_reg) : T_W'(0));
        sub1  = (sum  >= m_ext) ? sum  - m_ext : sum;
        sub2  = (sub1 >= m_ext) ? sub1 - m_ext : sub1;
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        x_next    = x_reg;
        m_next    = m_reg;
        r_next    = r_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(OP_W);
            a_next    = a;
            x_next    = x;
            m_next    = m;
            r_next    = '0;
        end
        else if (busy_reg)
        begin
            r_next   = sub2[MOD_BITS-1:0];
            a_next   = {a_reg[OP_W-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        x_reg <= x_next;
        m_reg <= m_next;
        r_reg <= r_next;
    end

    assign done   = done_reg;
    assign result = r_reg;

endmodule

`default_nettype wire

// ===== hdl/mexp_seq.sv =====
// ----------------------------------------------------------------------------
// mexp_seq: square-and-multiply sequencer
// Walks the exponent from bit 0 upward, issuing multiplies to the shared
// modular multiplier; stops as soon as no exponent bits remain.
// ----------------------------------------------------------------------------
`default_nettype none

module mexp_seq #(
    parameter int MOD_BITS = 31
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [mexp_pkg::BASE_W-1:0]    in_base,
    input  wire logic [mexp_pkg::EXP_W-1:0]     in_exp,
    input  wire logic [MOD_BITS-1:0]            modulus,
    output logic                                res_valid,
    input  wire logic                           res_ready,
    output logic [MOD_BITS-1:0]                 result
);
    import mexp_pkg::*;

    state_t state_reg, state_next;
    logic   start_reg, start_next;

    logic [BASE_W-1:0]   base_reg, base_next;
    logic [EXP_W-1:0]    exp_reg, exp_next;
    logic [MOD_BITS-1:0] mod_reg, mod_next;
    logic [MOD_BITS-1:0] acc_reg, acc_next;
    logic [MOD_BITS-1:0] sq_reg, sq_next;

    logic [MOD_BITS-1:0] one_m;
    logic [OP_W-1:0]     mul_a;
    logic [MOD_BITS-1:0] mul_x;
    logic                mul_done;
    logic [MOD_BITS-1:0] mul_res;

    assign one_m = (mod_reg == MOD_BITS'(1)) ? '0 : MOD_BITS'(1);

    always_comb
    begin
        unique case (state_reg)
            S_BASE:
            begin
                mul_a = base_reg;
                mul_x = one_m;
            end
            S_MUL:
            begin
                mul_a = OP_W'(acc_reg);
                mul_x = sq_reg;
            end
            default:
            begin
                mul_a = OP_W'(sq_reg);
                mul_x = sq_reg;
            end
        endcase
    end

    mexp_modmul #(
        .MOD_BITS (MOD_BITS)
    ) u_modmul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start_reg),
        .a      (mul_a),
        .x      (mul_x),
        .m      (mod_reg),
        .done   (mul_done),
        .result (mul_res)
    );

    always_comb
    begin
        state_next = state_reg;
        start_next = 1'b0;
        base_next  = base_reg;
        exp_next   = exp_reg;
        mod_next   = mod_reg;
        acc_next   = acc_reg;
        sq_next    = sq_reg;
        in_ready   = 1'b0;
        res_valid  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    base_next = in_base;
                    exp_next  = in_exp;
                    mod_next  = modulus;
                    if (modulus == '0)
                    begin
                        acc_next   = '0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        acc_next   = (modulus == MOD_BITS'(1)) ? '0 : MOD_BITS'(1);
                        start_next = 1'b1;
                        state_next = S_BASE;
                    end
                end
            end
            S_BASE:
            begin
                if (mul_done)
                begin
                    sq_next = mul_res;
                    if (exp_reg == '0)
                        state_next = S_DONE;
                    else
                    begin
                        start_next = 1'b1;
                        state_next = exp_reg[0] ? S_MUL : S_SQR;
                    end
                end
            end
            S_MUL:
            begin
                if (mul_done)
                begin
                    acc_next = mul_res;
                    if (exp_reg[EXP_W-1:1] == '0)
                        state_next = S_DONE;
                    else
                    begin
                        start_next = 1'b1;
                        state_next = S_SQR;
                    end
                end
            end
            S_SQR:
            begin
                // only entered while higher exponent bits remain
                if (mul_done)
                begin
                    sq_next    = mul_res;
                    exp_next   = {1'b0, exp_reg[EXP_W-1:1]};
                    start_next = 1'b1;
                    state_next = exp_reg[1] ? S_MUL : S_SQR;
                end
            end
            S_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            start_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= start_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg <= base_next;
        exp_reg  <= exp_next;
        mod_reg  <= mod_next;
        acc_reg  <= acc_next;
        sq_reg   <= sq_next;
    end

    assign result = acc_reg;

endmodule

`default_nettype wire

// ===== hdl/modular_exponentiation.sv =====
// ----------------------------------------------------------------------------
// modular_exponentiation: base^exponent mod modulus, square and multiply
// Stream in, stream out, one result per request; modulus set over cfg.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake                | payload
//  s_axis   | in  | s_axis_tvalid/tready     | tdata: base_value[31:0], exponent[94:32]
//  m_axis   | out | m_axis_tvalid/tready     | tdata: power_mod[MOD_BITS-1:0]
//  cfg      | in  | cfg_valid/cfg_ready      | cfg_data: modulus
//
//  Each modular multiply runs on the one bit-serial unit (load, 32 bit steps,
//  hand-off). A request holds the sequencer for n = k + h multiplies for a
//  nonzero exponent, with h the index+1 of the highest set exponent bit and
//  k its popcount.
//  Exponent zero needs only the base step (n = 1); modulus zero none (n = 0).
//  cfg_ready is always high; the modulus resets to 1.
//  A finished result sits in the output register, so the next request is
//  taken while m_axis is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module modular_exponentiation #(
    parameter int MOD_BITS = 31
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [mexp_pkg::IN_W-1:0]      s_axis_tdata,   // base_value, exponent, pad
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic [((MOD_BITS+7)/8)*8-1:0]       m_axis_tdata,   // power_mod, pad
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [MOD_BITS-1:0]            cfg_data        // modulus
);
    import mexp_pkg::*;

    localparam int OUT_W = ((MOD_BITS + 7) / 8) * 8;

    logic [MOD_BITS-1:0] modulus_reg, modulus_next;
    logic                out_valid_reg, out_valid_next;
    logic [MOD_BITS-1:0] out_data_reg, out_data_next;

    logic                seq_valid;
    logic                seq_ready;
    logic [MOD_BITS-1:0] seq_result;

    assign cfg_ready    = 1'b1;
    assign modulus_next = (cfg_valid && cfg_ready) ? cfg_data : modulus_reg;

    mexp_seq #(
        .MOD_BITS (MOD_BITS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_base   (s_axis_tdata[BASE_W-1:0]),
        .in_exp    (s_axis_tdata[BASE_W+EXP_W-1:BASE_W]),
        .modulus   (modulus_reg),
        .res_valid (seq_valid),
        .res_ready (seq_ready),
        .result    (seq_result)
    );

    assign seq_ready = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (m_axis_tready)
            out_valid_next = 1'b0;
        if (seq_valid && seq_ready)
        begin
            out_valid_next = 1'b1;
            out_data_next  = seq_result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg   <= MOD_BITS'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            modulus_reg   <= modulus_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_W'(out_data_reg);

    // a taken request leaves the sequencer not ready in the cycle after
    a_busy_after_request: assert property (
        @(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready
    ) else $error("sequencer ready right after taking a request");

    // a finished result held back by the output register must not change
    a_result_held: assert property (
        @(posedge clk) disable iff (!rst_n)
        (seq_valid && !seq_ready) |=> (seq_valid && $stable(seq_result))
    ) else $error("sequencer result changed while stalled");

endmodule

`default_nettype wire
